@@ src/cdq_pkg.sv @@
package cdq_pkg;

  // default geometry of the store
  localparam int unsigned DepthDef     = 8;
  localparam int unsigned DataWidthDef = 32;

  // operation codes carried by a request
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK       = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOOK,
    S_CAP
  } ctrl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // take the request into the datapath
    logic exec;     // run the operation, pointer update and slot access
    logic look;     // read the front and rear slots
    logic capture;  // move the result into the output register
  } cmd_t;

endpackage

@@ src/cdq_ctrl.sv @@
module cdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cdq_pkg::cmd_t cmd_o
);
  import cdq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_LOOK;
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_CAP;
      end
      S_CAP: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/cdq_datapath.sv @@
module cdq_datapath #(
  parameter int unsigned DEPTH      = cdq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DataWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdq_pkg::cmd_t       cmd_i,
  input  logic [2:0]          op_i,
  input  logic signed [31:0]  value_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  popped_value_o,
  output logic signed [31:0]  front_value_o,
  output logic signed [31:0]  rear_value_o,
  output logic                is_empty_o,
  output logic                is_full_o,
  output logic [3:0]          occupancy_o
);
  import cdq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  function automatic logic [IdxW-1:0] idx_up(logic [IdxW-1:0] i);
    return (i == IdxLast) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_down(logic [IdxW-1:0] i);
    return (i == '0) ? IdxLast : i - 1'b1;
  endfunction

  // sign-extend a stored word, keep the low 32 bits
  function automatic logic [31:0] word_out(logic [DATA_WIDTH-1:0] w);
    logic signed [63:0] e;
    e = 64'($signed(w));
    return e[31:0];
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [2:0]            op_q;
  logic signed [31:0]    value_q;
  logic [IdxW-1:0]       head_q, head_d;
  logic [IdxW-1:0]       tail_q, tail_d;
  logic [CntW-1:0]       count_q, count_d;
  status_e               status_q, status_d;
  logic                  pop_ok_q, pop_ok_d;
  logic [31:0]           popped_q;
  logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q;

  logic                  we;
  logic [IdxW-1:0]       wa;
  logic [DATA_WIDTH-1:0] wd;
  logic                  re_a, re_b;
  logic [IdxW-1:0]       ra_a, ra_b;
  logic signed [63:0]    push_ext;
  logic                  is_push, is_pop, at_front, empty, full;

  // request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      value_q <= value_i;
    end
  end

  always_comb begin
    is_push  = 1'b0;
    is_pop   = 1'b0;
    at_front = 1'b0;
    case (op_q)
      OP_PUSH_FRONT: begin
        is_push  = 1'b1;
        at_front = 1'b1;
      end
      OP_PUSH_REAR: begin
        is_push = 1'b1;
      end
      OP_POP_FRONT: begin
        is_pop   = 1'b1;
        at_front = 1'b1;
      end
      OP_POP_REAR: begin
        is_pop = 1'b1;
      end
      default: begin
        // peek and unused codes leave the state alone
      end
    endcase
  end

  assign empty    = (count_q == '0);
  assign full     = (count_q == CntFull);
  assign push_ext = 64'(value_q);
  assign wd       = push_ext[DATA_WIDTH-1:0];

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    we       = 1'b0;
    wa       = '0;
    re_a     = 1'b0;
    re_b     = 1'b0;
    ra_a     = head_q;
    ra_b     = tail_q;
    if (cmd_i.exec) begin
      status_d = ST_DONE;
      pop_ok_d = 1'b0;
      if (is_push) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
          if (empty) begin
            head_d = '0;
            tail_d = '0;
            wa     = '0;
          end else if (at_front) begin
            head_d = idx_down(head_q);
            wa     = idx_down(head_q);
          end else begin
            tail_d = idx_up(tail_q);
            wa     = idx_up(tail_q);
          end
        end
      end else if (is_pop) begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          pop_ok_d = 1'b1;
          re_a     = 1'b1;
          ra_a     = at_front ? head_q : tail_q;
          count_d  = count_q - 1'b1;
          if (count_q == CntW'(1)) begin
            head_d = '0;
            tail_d = '0;
          end else if (at_front) begin
            head_d = idx_up(head_q);
          end else begin
            tail_d = idx_down(tail_q);
          end
        end
      end
    end
    if (cmd_i.look) begin
      re_a = 1'b1;
      re_b = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      pop_ok_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  // slot store, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re_a) begin
      rd_a_q <= mem[ra_a];
    end
    if (re_b) begin
      rd_b_q <= mem[ra_b];
    end
  end

  // popped word is taken in the look step, the cycle after the exec read
  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      popped_q <= pop_ok_q ? word_out(rd_a_q) : '0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      status_o       <= status_q;
      popped_value_o <= popped_q;
      front_value_o  <= empty ? '1 : word_out(rd_a_q);
      rear_value_o   <= empty ? '1 : word_out(rd_b_q);
      is_empty_o     <= empty;
      is_full_o      <= full;
      occupancy_o    <= 4'(count_q);
    end
  end

endmodule

@@ src/circular_deque.sv @@
// double-ended queue of DEPTH signed words held in a circular slot store.
// each request carries an op (push front, push rear, pop front, pop rear,
// peek; unused codes act as a peek) and a 32-bit value, and gives exactly one
// result: status, popped word, front and rear words after the op (-1 when
// empty), empty and full flags and the word count (low 4 bits). a push onto a
// full deque or a pop from an empty one is refused and changes nothing.
// a request steps through the accepting state, a state for the pointer update
// and slot access, one for the front and rear slot reads and one to load the
// output register. a new request is taken only once the last one's result is
// loaded. the slot store's registered read ports give the reads their own steps.
// the load waits while the output register still holds an unread result. the
// next request is accepted while a result still waits in the output register.
// slots need no clearing after reset, an empty deque never shows them.
module circular_deque #(
  parameter int unsigned DEPTH      = cdq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DataWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] popped_value_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] rear_value_o,
  output logic               is_empty_o,
  output logic               is_full_o,
  output logic [3:0]         occupancy_o
);
  import cdq_pkg::*;

  // sequencer commands into the datapath
  cmd_t cmd;

  // controller: request handshake, step sequence, output register valid
  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // datapath: pointers, count, slot store and the result register
  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .value_i        (value_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .front_value_o  (front_value_o),
    .rear_value_o   (rear_value_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

@@ tb/tb_circular_deque.sv @@
module tb_circular_deque;
  import cdq_pkg::*;

  // geometry and run shape
  localparam int unsigned DEPTH           = DepthDef;
  localparam int          MAX_WAIT        = 13;
  localparam int          HOLD_CYCLES     = 150;
  localparam int          QUIET_LIMIT     = 2000;
  localparam int          RANDOM_REQUESTS = 1000;
  localparam int          TAIL_CYCLES     = 20;
  localparam int          REPORT_LIMIT    = 10;

  // op codes past the last defined one behave as a peek
  localparam logic [2:0] FIRST_SPARE_OP = 3'(OP_PEEK + 1);
  localparam logic [2:0] LAST_OP_CODE   = 3'd7;

  // notable words
  localparam logic signed [31:0] WORD_MAX   = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] ALL_ONES   = -32'sd1;
  localparam logic signed [31:0] EMPTY_MARK = -32'sd1;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped;
    logic signed [31:0] front;
    logic signed [31:0] rear;
    logic               is_empty;
    logic               is_full;
    logic [3:0]         occupancy;
  } outcome_t;

  // mirror of the deque plus the queue of outcomes still owed by the block
  class deque_tracker;
    logic signed [31:0] words[DEPTH];
    int unsigned head, tail, fill;
    outcome_t pending[$];
    int unsigned noted, checked, mismatches, strays, reported;
    int unsigned refused_full, refused_empty, peak;

    function void note_request(logic [2:0] op, logic signed [31:0] val);
      outcome_t o;
      o.status = ST_DONE;
      o.popped = '0;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
        if (fill == DEPTH) begin
          o.status = ST_FULL;
          refused_full++;
        end else begin
          // first word of an empty deque always lands in slot zero
          if (fill == 0) begin
            head = 0;
            tail = 0;
            words[0] = val;
          end else if (op == OP_PUSH_FRONT) begin
            head = (head == 0) ? DEPTH - 1 : head - 1;
            words[head] = val;
          end else begin
            tail = (tail == DEPTH - 1) ? 0 : tail + 1;
            words[tail] = val;
          end
          fill++;
        end
      end else if (op == OP_POP_FRONT || op == OP_POP_REAR) begin
        if (fill == 0) begin
          o.status = ST_EMPTY;
          refused_empty++;
        end else begin
          if (op == OP_POP_FRONT) begin
            o.popped = words[head];
            head = (head == DEPTH - 1) ? 0 : head + 1;
          end else begin
            o.popped = words[tail];
            tail = (tail == 0) ? DEPTH - 1 : tail - 1;
          end
          fill--;
          // draining to empty sends both ends home
          if (fill == 0) begin
            head = 0;
            tail = 0;
          end
        end
      end
      o.front     = (fill == 0) ? EMPTY_MARK : words[head];
      o.rear      = (fill == 0) ? EMPTY_MARK : words[tail];
      o.is_empty  = (fill == 0);
      o.is_full   = (fill == DEPTH);
      o.occupancy = 4'(fill);
      if (fill > peak) peak = fill;
      noted++;
      pending.push_back(o);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("result %0d, %s: expected 0x%h, got 0x%h", checked, name, want, got);
        end
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        strays++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("result with no request outstanding: status %0d occupancy %0d",
                   got.status, got.occupancy);
        end
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("popped value", want.popped, got.popped);
      compare_field("front value", want.front, got.front);
      compare_field("rear value", want.rear, got.rear);
      compare_field("empty flag", 32'(want.is_empty), 32'(got.is_empty));
      compare_field("full flag", 32'(want.is_full), 32'(got.is_full));
      compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [2:0]         op_i        = OP_PEEK;
  logic signed [31:0] value_i     = '0;
  logic               out_stall_i = 1'b0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] popped_value_o;
  logic signed [31:0] front_value_o;
  logic signed [31:0] rear_value_o;
  logic               is_empty_o;
  logic               is_full_o;
  logic [3:0]         occupancy_o;

  deque_tracker tracker = new();

  // idle behaviour: each side switches now and then between gappy and steady
  bit          send_steady = 1'b0;
  bit          take_steady = 1'b0;
  int unsigned sent        = 0;
  int unsigned taken       = 0;
  int unsigned holds       = 0;

  always #2 clk_i = ~clk_i;

  circular_deque dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .front_value_o  (front_value_o),
    .rear_value_o   (rear_value_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .occupancy_o    (occupancy_o)
  );

  // mostly random words, with the extremes of the signed range mixed in
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return ALL_ONES;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // pushes dominate while filling, pops while draining; a few peeks and spare codes
  function automatic logic [2:0] pick_op(bit filling);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return OP_PEEK;
    if (roll < 10) return 3'($urandom_range(FIRST_SPARE_OP, LAST_OP_CODE));
    if ((roll < 73) == filling) return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
  endfunction

  // offer one request after a drawn gap and hold it until the block takes it
  task automatic offer_request(input logic [2:0] op, input logic signed [31:0] val);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_request(op, val);
    sent++;
    if (sent % 64 == 0) send_steady = ($urandom_range(0, 3) == 0);
  endtask

  // result side: stall for a drawn number of cycles, then take the next result
  initial begin : result_sink
    int       gap;
    outcome_t got;
    @(posedge rst_ni);
    forever begin
      // two long hold-offs so the pipeline backs up into the request side
      if (taken == 200 || taken == 600) begin
        gap = HOLD_CYCLES;
        holds++;
      end else begin
        gap = take_steady ? 0 : $urandom_range(0, MAX_WAIT);
      end
      @(negedge clk_i);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.status    = status_o;
      got.popped    = popped_value_o;
      got.front     = front_value_o;
      got.rear      = rear_value_o;
      got.is_empty  = is_empty_o;
      got.is_full   = is_full_o;
      got.occupancy = occupancy_o;
      tracker.check_result(got);
      taken++;
      if (taken % 64 == 0) take_steady = ($urandom_range(0, 3) == 0);
    end
  end

  // watchdog: too long without any request moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : run
    bit filling;
    int phase_left;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // refusals and peek on an empty deque
    offer_request(OP_POP_FRONT, $urandom);
    offer_request(OP_POP_REAR, $urandom);
    offer_request(OP_PEEK, $urandom);
    // single word in and out again, ends return to slot zero
    offer_request(OP_PUSH_REAR, WORD_MAX);
    offer_request(OP_POP_FRONT, $urandom);
    // a second front push wraps the head below zero, a front pop wraps it back
    offer_request(OP_PUSH_FRONT, WORD_MIN);
    offer_request(OP_PUSH_FRONT, ALL_ONES);
    offer_request(OP_POP_FRONT, $urandom);
    offer_request(OP_POP_REAR, $urandom);
    // fill from the rear up to the last slot
    offer_request(OP_PUSH_REAR, '0);
    for (int i = 0; i < DEPTH - 1; i++) offer_request(OP_PUSH_REAR, pick_word());
    // refused pushes and a spare code on a full deque
    offer_request(OP_PUSH_FRONT, $urandom);
    offer_request(OP_PUSH_REAR, $urandom);
    offer_request(FIRST_SPARE_OP, $urandom);
    // free the front slot, then the tail wraps past the top and back
    offer_request(OP_POP_FRONT, $urandom);
    offer_request(OP_PUSH_REAR, pick_word());
    offer_request(OP_POP_REAR, $urandom);
    offer_request(LAST_OP_CODE, $urandom);
    offer_request(FIRST_SPARE_OP + 3'd1, $urandom);

    // random part: alternate filling and draining spells so both ends get hit
    filling    = 1'b1;
    phase_left = 0;
    repeat (RANDOM_REQUESTS) begin
      if (phase_left == 0) begin
        filling    = ~filling;
        phase_left = $urandom_range(8, 40);
      end
      phase_left--;
      offer_request(pick_op(filling), pick_word());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain, then a short tail to catch any extra result
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked, %0d long result hold-offs",
             tracker.noted, tracker.checked, holds);
    $display("deque reached %0d words; %0d pushes refused full, %0d pops refused empty",
             tracker.peak, tracker.refused_full, tracker.refused_empty);
    if (tracker.mismatches == 0 && tracker.strays == 0 && tracker.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d field mismatches, %0d unexpected results, %0d results missing",
               tracker.mismatches, tracker.strays, tracker.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
